@@ rtl/mt19937_random_generator_macros.svh @@
// assertion helpers shared by the generator rtl
`ifndef MT19937_RANDOM_GENERATOR_MACROS_SVH
`define MT19937_RANDOM_GENERATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define MTRG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MTRG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mtrg_pkg.sv @@
package mtrg_pkg;

    // field and store geometry
    localparam int ACTION_W    = 2;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 5;
    localparam int STATE_WORDS = 624;
    localparam int SHIFT_DIST  = 397;
    localparam int FAR_WRAP    = STATE_WORDS - SHIFT_DIST;

    // generator constants
    localparam logic [WORD_W-1:0] TWIST_XOR = 32'h9908b0df;
    localparam logic [WORD_W-1:0] TOP_BIT   = 32'h80000000;
    localparam logic [WORD_W-1:0] LOW_BITS  = 32'h7fffffff;
    localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc60000;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_SEED  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DRAW  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RANGE = 2'd2;

    // sequencer states
    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_SEED_MUL = 10'b00_0000_0010,
        ST_SEED_WR = 10'b00_0000_0100,
        ST_TW_INIT = 10'b00_0000_1000,
        ST_TW_RD   = 10'b00_0001_0000,
        ST_TW_WR   = 10'b00_0010_0000,
        ST_RD      = 10'b00_0100_0000,
        ST_RDW     = 10'b00_1000_0000,
        ST_DIV     = 10'b01_0000_0000,
        ST_OUT     = 10'b10_0000_0000
    } mtrg_state_t;

    // one twist step on three store words
    function automatic logic [WORD_W-1:0] mix_pair(
        input logic [WORD_W-1:0] upper_src,
        input logic [WORD_W-1:0] lower_src,
        input logic [WORD_W-1:0] far
    );
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] r;
        y = (upper_src & TOP_BIT) | (lower_src & LOW_BITS);
        r = far ^ (y >> 1);
        if (y[0])
        begin
            r = r ^ TWIST_XOR;
        end
        return r;
    endfunction

    // output tempering
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ rtl/mtrg_cmd_if.sv @@
interface mtrg_cmd_if import mtrg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   seed;
    logic [WORD_W-1:0]   range_low;
    logic [WORD_W-1:0]   range_high;

    modport source (output valid, action, seed, range_low, range_high, input ready);
    modport sink   (input valid, action, seed, range_low, range_high, output ready);
endinterface

@@ rtl/mtrg_res_if.sv @@
interface mtrg_res_if import mtrg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] value;

    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

@@ rtl/mt19937_random_generator.sv @@
// channel  dir  beat payload
// -------  ---  ----------------------------------------------
// cmd      in   action, seed, range_low, range_high
// res      out  value (one beat for draw and range actions)
//
// a raw draw passes through the read state (ST_RD), the read-wait state (ST_RDW) set by the store's
// registered read, and the output state (ST_OUT); every 624th draw first twists the store, reading
// and then writing each word on the store ports; a range draw adds a bit-serial remainder over the
// 32 dividend bits; a seed passes through the seeding multiplier and a store write for each word
// no clearing pass after reset: a seeded flag makes the store read as zero until seeded
// cmd is taken only while idle; a waiting result in the output register does not block it
`include "mt19937_random_generator_macros.svh"

module mt19937_random_generator import mtrg_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    mtrg_cmd_if.sink   cmd,
    mtrg_res_if.source res
);

    localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(STATE_WORDS - 1);

    // state store and its read registers
    logic [WORD_W-1:0] mem [STATE_WORDS];
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr_a;
    logic [IDX_W-1:0]  rd_addr_b;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // control registers
    mtrg_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             seeded_reg, seeded_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] k_reg, k_next;

    // payload registers
    logic [WORD_W-1:0]   cur_reg, cur_next;
    logic [WORD_W-1:0]   prod_reg, prod_next;
    logic [WORD_W-1:0]   dvd_reg, dvd_next;
    logic [WORD_W-1:0]   rem_reg, rem_next;
    logic [WORD_W-1:0]   lo_reg, lo_next;
    logic [WORD_W-1:0]   span_reg, span_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [WORD_W-1:0]   result_reg, result_next;
    logic [WORD_W-1:0]   out_val_reg, out_val_next;

    // datapath helpers
    logic              cmd_fire;
    logic              out_load;
    logic [IDX_W-1:0]  tw_next_addr;
    logic [IDX_W-1:0]  tw_far_addr;
    logic [WORD_W-1:0] draw_raw;
    logic [WORD_W-1:0] draw_tempered;
    logic [WORD_W:0]   div_trial;
    logic [WORD_W:0]   div_diff;
    logic [WORD_W-1:0] rem_step;
    logic [WORD_W-1:0] seed_mix;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && (state_reg == ST_IDLE);
    assign res.valid = out_valid_reg;
    assign res.value = out_val_reg;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || res.ready);

    // twist neighbor addresses with wrap
    assign tw_next_addr = (k_reg == LAST_WORD) ? '0 : k_reg + 1'b1;
    assign tw_far_addr  = (k_reg < IDX_W'(FAR_WRAP)) ? k_reg + IDX_W'(SHIFT_DIST)
                                                     : k_reg - IDX_W'(FAR_WRAP);

    // unseeded store reads as zero
    assign draw_raw      = seeded_reg ? rd_a_reg : '0;
    assign draw_tempered = temper(draw_raw);

    // one restoring remainder step
    assign div_trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign div_diff  = div_trial - {1'b0, span_reg};
    assign rem_step  = (div_trial >= {1'b0, span_reg}) ? div_diff[WORD_W-1:0]
                                                       : div_trial[WORD_W-1:0];

    assign seed_mix = cur_reg ^ (cur_reg >> 30);

    // store port control
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr_a = tw_next_addr;
        rd_addr_b = tw_far_addr;
        mem_we    = 1'b0;
        mem_waddr = k_reg;
        mem_wdata = mix_pair(cur_reg, rd_a_reg, rd_b_reg);
        case (state_reg)
            ST_IDLE:
            begin
                mem_we    = cmd_fire && (cmd.action == ACT_SEED);
                mem_waddr = '0;
                mem_wdata = cmd.seed;
            end
            ST_SEED_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = prod_reg + WORD_W'(k_reg);
            end
            ST_TW_INIT:
            begin
                rd_en     = 1'b1;
                rd_addr_a = '0;
            end
            ST_TW_RD:
            begin
                rd_en = 1'b1;
            end
            ST_TW_WR:
            begin
                mem_we = 1'b1;
            end
            ST_RD:
            begin
                rd_en     = 1'b1;
                rd_addr_a = idx_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        seeded_next    = seeded_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        prod_next      = prod_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        lo_next        = lo_reg;
        span_next      = span_reg;
        act_next       = act_reg;
        result_next    = result_reg;
        out_val_next   = out_val_reg;
        out_valid_next = out_valid_reg;

        // output register
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_val_next   = result_reg;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    act_next  = cmd.action;
                    lo_next   = cmd.range_low;
                    span_next = cmd.range_high - cmd.range_low + 1'b1;
                    if (cmd.action == ACT_SEED)
                    begin
                        cur_next   = cmd.seed;
                        k_next     = IDX_W'(1);
                        state_next = ST_SEED_MUL;
                    end
                    else if (cmd.action inside {ACT_DRAW, ACT_RANGE})
                    begin
                        if (!seeded_reg)
                        begin
                            state_next = ST_RDW;
                        end
                        else if (idx_reg >= IDX_W'(STATE_WORDS))
                        begin
                            state_next = ST_TW_INIT;
                        end
                        else
                        begin
                            state_next = ST_RD;
                        end
                    end
                end
            end
            ST_SEED_MUL:
            begin
                prod_next  = WORD_W'(SEED_MULT * seed_mix);
                state_next = ST_SEED_WR;
            end
            ST_SEED_WR:
            begin
                cur_next = mem_wdata;
                if (k_reg == LAST_WORD)
                begin
                    idx_next    = IDX_W'(STATE_WORDS);
                    seeded_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SEED_MUL;
                end
            end
            ST_TW_INIT:
            begin
                k_next     = '0;
                state_next = ST_TW_RD;
            end
            ST_TW_RD:
            begin
                // old word k was fetched as the previous step's neighbor
                cur_next   = rd_a_reg;
                state_next = ST_TW_WR;
            end
            ST_TW_WR:
            begin
                if (k_reg == LAST_WORD)
                begin
                    idx_next   = '0;
                    state_next = ST_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_TW_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_RDW;
            end
            ST_RDW:
            begin
                idx_next = idx_reg + 1'b1;
                if ((act_reg == ACT_RANGE) && (span_reg != '0))
                begin
                    dvd_next   = draw_tempered;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    result_next = draw_tempered;
                    state_next  = ST_OUT;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    result_next = lo_reg + rem_step;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= IDX_W'(STATE_WORDS + 1);
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        prod_reg    <= prod_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        lo_reg      <= lo_next;
        span_reg    <= span_next;
        act_reg     <= act_next;
        result_reg  <= result_next;
        out_val_reg <= out_val_next;
    end

    // state store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    // checks
    `MTRG_ASSERT_IMP(a_draw_index_in_range, (state_reg == ST_RD), (idx_reg < IDX_W'(STATE_WORDS)), "draw read past store")
    `MTRG_ASSERT_IMP(a_write_in_range, mem_we, (mem_waddr < IDX_W'(STATE_WORDS)), "store write past end")
    `MTRG_ASSERT_NXT(a_seed_arms_twist, (state_reg == ST_SEED_WR) && (k_reg == LAST_WORD), (idx_reg == IDX_W'(STATE_WORDS)) && seeded_reg, "seed did not arm twist")
    `MTRG_ASSERT_NXT(a_div_ends, (state_reg == ST_DIV) && (cnt_reg == '1), (state_reg == ST_OUT), "remainder did not finish")

endmodule

@@ dv/mtrg_checker.sv @@
`timescale 1ns / 1ps

// watches both channels, predicts each draw and compares result beats in order
module mtrg_checker import mtrg_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    mtrg_cmd_if  cmd,
    mtrg_res_if  res,
    output int   mismatches,
    output int   pending_results
);

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the generator store
    logic [WORD_W-1:0] shadow_words [STATE_WORDS];
    int unsigned       shadow_index;

    // predicted values still waiting for their result beat
    logic [WORD_W-1:0] expected_values [$];
    logic [WORD_W-1:0] oldest_value;

    // regenerate the whole store in place
    task automatic regen_shadow();
        logic [WORD_W-1:0] joined;
        logic [WORD_W-1:0] mixed;
        for (int k = 0; k < STATE_WORDS; k++)
        begin
            joined = (shadow_words[k] & TOP_BIT)
                   | (shadow_words[(k + 1) % STATE_WORDS] & LOW_BITS);
            mixed  = shadow_words[(k + SHIFT_DIST) % STATE_WORDS] ^ (joined >> 1);
            if (joined[0])
            begin
                mixed = mixed ^ TWIST_XOR;
            end
            shadow_words[k] = mixed;
        end
        shadow_index = 0;
    endtask

    // next tempered word, twisting first when the store is used up
    task automatic pull_tempered(output logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] y;
        if (shadow_index >= STATE_WORDS)
        begin
            regen_shadow();
        end
        y = shadow_words[shadow_index % STATE_WORDS];
        shadow_index++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        word = y;
    endtask

    // standard seeding recurrence
    task automatic seed_shadow(input logic [WORD_W-1:0] seed_word);
        logic [WORD_W-1:0] prev;
        shadow_words[0] = seed_word;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            prev = shadow_words[i - 1];
            shadow_words[i] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
        end
        shadow_index = STATE_WORDS;
    endtask

    // work out what one command beat produces
    task automatic predict_command(
        input logic [ACTION_W-1:0] act,
        input logic [WORD_W-1:0]   seed_word,
        input logic [WORD_W-1:0]   lo,
        input logic [WORD_W-1:0]   hi
    );
        logic [WORD_W-1:0] draw;
        logic [WORD_W-1:0] span;
        case (act)
            ACT_SEED:
            begin
                seed_shadow(seed_word);
            end
            ACT_DRAW:
            begin
                pull_tempered(draw);
                expected_values.push_back(draw);
            end
            ACT_RANGE:
            begin
                pull_tempered(draw);
                span = hi - lo + 1'b1;
                if (span == '0)
                begin
                    expected_values.push_back(draw);
                end
                else
                begin
                    expected_values.push_back(lo + draw % span);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic note_failure();
        mismatches++;
    endtask

    // state after reset: store zero, index past the end
    initial
    begin
        mismatches      = 0;
        pending_results = 0;
        shadow_index    = STATE_WORDS + 1;
        for (int i = 0; i < STATE_WORDS; i++)
        begin
            shadow_words[i] = '0;
        end
    end

    // result beats first, since a command beat cannot finish in the same cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("unexpected result beat: value %h", res.value);
                    end
                    note_failure();
                end
                else
                begin
                    oldest_value = expected_values.pop_front();
                    if (res.value !== oldest_value)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display("value mismatch: expected %h actual %h",
                                     oldest_value, res.value);
                        end
                        note_failure();
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                predict_command(cmd.action, cmd.seed, cmd.range_low, cmd.range_high);
            end
        end
        pending_results <= expected_values.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import mtrg_pkg::*; ();

    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 1400;

    logic clk = 1'b0;
    logic rst_n;

    mtrg_cmd_if cmd_ch ();
    mtrg_res_if res_ch ();

    int mismatches;
    int pending_results;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;

    mt19937_random_generator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    mtrg_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_ch),
        .res             (res_ch),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result ready: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            res_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_served  <= hold_requests;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // offer one command beat and wait until it is taken
    task automatic send_beat(
        input logic [ACTION_W-1:0] act,
        input logic [WORD_W-1:0]   seed_word,
        input logic [WORD_W-1:0]   lo,
        input logic [WORD_W-1:0]   hi
    );
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.action     <= act;
        cmd_ch.seed       <= seed_word;
        cmd_ch.range_low  <= lo;
        cmd_ch.range_high <= hi;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // drop valid and wait until every predicted value has come back
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results != 0);
    endtask

    function automatic logic [WORD_W-1:0] corner_word();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            default: return 32'h7fff_ffff;
        endcase
    endfunction

    // random commands; unused-action beats are extra noise and not counted
    task automatic send_random_beats(input int count, input int seed_pct);
        int                sent;
        int                pick;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            // bounds: wide random, narrow window, from zero, or corners
            case ($urandom_range(3))
                0:
                begin
                    lo = $urandom;
                    hi = $urandom;
                end
                1:
                begin
                    lo = $urandom;
                    hi = lo + $urandom_range(1000);
                end
                2:
                begin
                    lo = '0;
                    hi = ($urandom_range(1)) ? $urandom_range(255)
                                             : (32'h1 << $urandom_range(31)) - 1;
                end
                default:
                begin
                    lo = corner_word();
                    hi = corner_word();
                end
            endcase
            if (pick < 2)
            begin
                send_beat(ACT_NONE, $urandom, lo, hi);
            end
            else if (pick < 2 + seed_pct)
            begin
                send_beat(ACT_SEED, ($urandom_range(3) == 0) ? corner_word() : $urandom,
                          lo, hi);
                sent++;
            end
            else if (pick < 50)
            begin
                send_beat(ACT_DRAW, $urandom, lo, hi);
                sent++;
            end
            else
            begin
                send_beat(ACT_RANGE, $urandom, lo, hi);
                sent++;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        cmd_ch.valid      = 1'b0;
        cmd_ch.action     = ACT_SEED;
        cmd_ch.seed       = '0;
        cmd_ch.range_low  = '0;
        cmd_ch.range_high = '0;
        res_ch.ready      = 1'b0;
        rst_n             = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unseeded store reads zero, unused action does nothing
        send_beat(ACT_DRAW, '0, '0, '0);
        send_beat(ACT_RANGE, '0, 32'd5, 32'd9);
        send_beat(ACT_NONE, '1, '1, '1);
        send_beat(ACT_DRAW, '1, '1, '1);

        // seed extremes and the common default seed
        send_beat(ACT_SEED, 32'h0000_0000, '0, '0);
        send_beat(ACT_DRAW, '0, '0, '0);
        send_beat(ACT_SEED, 32'hffff_ffff, '1, '1);
        send_beat(ACT_DRAW, '0, '0, '0);
        send_beat(ACT_SEED, 32'd5489, '0, '0);
        send_beat(ACT_DRAW, '0, '0, '0);
        send_beat(ACT_DRAW, '1, '1, '1);

        // full span in three spellings returns the raw draw
        send_beat(ACT_RANGE, '0, 32'h0000_0000, 32'hffff_ffff);
        send_beat(ACT_RANGE, '0, 32'h0000_0001, 32'h0000_0000);
        send_beat(ACT_RANGE, '0, 32'h8000_0000, 32'h7fff_ffff);

        // single-value, inverted and near-full ranges
        send_beat(ACT_RANGE, '1, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(ACT_RANGE, '0, 32'h0000_0000, 32'h0000_0000);
        send_beat(ACT_RANGE, '0, 32'hffff_0000, 32'h0000_0010);
        send_beat(ACT_RANGE, '0, 32'hffff_ff00, 32'hffff_ffff);
        send_beat(ACT_RANGE, '0, 32'h0000_0000, 32'hffff_fffe);
        send_beat(ACT_RANGE, '0, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(ACT_SEED, $urandom, '0, '0);
        send_beat(ACT_RANGE, '0, 32'h0000_0000, 32'h0000_0001);

        // no idling
        send_random_beats(100, 6);
        drain_results();

        // sender idles
        src_idle_pct = 73;
        send_random_beats(80, 6);

        // receiver stalls, with one long hold-off up front;
        // no seeds from here so the draws run through whole store passes
        src_idle_pct = 0;
        sink_stall_pct <= 73;
        hold_requests  <= hold_requests + 1;
        send_random_beats(330, 0);

        // both sides idle
        src_idle_pct = 22;
        sink_stall_pct <= 22;
        send_random_beats(330, 0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
